// ----- sv/mai_pkg.sv -----
`default_nettype none

package mai_pkg;

    localparam int FRAC_BITS = 16;

    // register file for accumulators and temporaries
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = $clog2(RF_DEPTH);
    localparam int DATA_W   = 64;
    localparam int PC_W     = 6;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Z = CFG_IDX_W'(3);

    localparam logic [31:0]  MASS_RESET = 32'(64'd1 << FRAC_BITS);
    localparam logic [127:0] RND_HALF   = 128'd1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [31:0] tri_cx;
        logic signed [31:0] tri_cy;
        logic signed [31:0] tri_cz;
        logic [31:0]        tri_area;
        logic               final_tri;
    } in_t;

    typedef struct packed {
        logic signed [31:0] cog_x;
        logic signed [31:0] cog_y;
        logic signed [31:0] cog_z;
        logic signed [47:0] inertia_xx;
        logic signed [47:0] inertia_yy;
        logic signed [47:0] inertia_zz;
        logic signed [47:0] inertia_xz;
        logic               area_error;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OPER,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_MULQ,
        OP_ADD,
        OP_SUB,
        OP_COG,
        OP_CENT,
        OP_SCALE,
        OP_BRANCH,
        OP_END
    } op_t;

    // codes below 32 are register file entries, the rest are item, config and result slots
    typedef enum logic [5:0] {
        LOC_SA  = 6'd0,
        LOC_SX  = 6'd1,
        LOC_SY  = 6'd2,
        LOC_SZ  = 6'd3,
        LOC_SXX = 6'd4,
        LOC_SYY = 6'd5,
        LOC_SZZ = 6'd6,
        LOC_SXZ = 6'd7,
        LOC_T0  = 6'd8,
        LOC_T1  = 6'd9,
        LOC_CX  = 6'd10,
        LOC_CY  = 6'd11,
        LOC_CZ  = 6'd12,
        LOC_XX2 = 6'd13,
        LOC_YY2 = 6'd14,
        LOC_ZZ2 = 6'd15,
        LOC_IXX = 6'd16,
        LOC_IYY = 6'd17,
        LOC_IZZ = 6'd18,
        LOC_IXZ = 6'd19,
        LOC_X   = 6'd32,
        LOC_Y   = 6'd33,
        LOC_Z   = 6'd34,
        LOC_A   = 6'd35,
        LOC_PX  = 6'd36,
        LOC_PY  = 6'd37,
        LOC_PZ  = 6'd38,
        LOC_OCX = 6'd40,
        LOC_OCY = 6'd41,
        LOC_OCZ = 6'd42,
        LOC_OXX = 6'd43,
        LOC_OYY = 6'd44,
        LOC_OZZ = 6'd45,
        LOC_OXZ = 6'd46
    } loc_t;

    typedef struct packed {
        op_t  op;
        loc_t s1;
        loc_t s2;
        loc_t dst;
    } uop_t;

    typedef struct packed {
        logic start;
        logic rnd;
    } mul_req_t;

    // microprogram: accumulation first, then the finishing sequence
    function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = '{OP_MULQ,   LOC_A,   LOC_X,   LOC_T0};
            6'd1:  u = '{OP_ADD,    LOC_SX,  LOC_T0,  LOC_SX};
            6'd2:  u = '{OP_MULQ,   LOC_A,   LOC_Y,   LOC_T0};
            6'd3:  u = '{OP_ADD,    LOC_SY,  LOC_T0,  LOC_SY};
            6'd4:  u = '{OP_MULQ,   LOC_A,   LOC_Z,   LOC_T0};
            6'd5:  u = '{OP_ADD,    LOC_SZ,  LOC_T0,  LOC_SZ};
            6'd6:  u = '{OP_MULQ,   LOC_X,   LOC_X,   LOC_T0};
            6'd7:  u = '{OP_MULQ,   LOC_A,   LOC_T0,  LOC_T0};
            6'd8:  u = '{OP_ADD,    LOC_SXX, LOC_T0,  LOC_SXX};
            6'd9:  u = '{OP_MULQ,   LOC_Y,   LOC_Y,   LOC_T0};
            6'd10: u = '{OP_MULQ,   LOC_A,   LOC_T0,  LOC_T0};
            6'd11: u = '{OP_ADD,    LOC_SYY, LOC_T0,  LOC_SYY};
            6'd12: u = '{OP_MULQ,   LOC_Z,   LOC_Z,   LOC_T0};
            6'd13: u = '{OP_MULQ,   LOC_A,   LOC_T0,  LOC_T0};
            6'd14: u = '{OP_ADD,    LOC_SZZ, LOC_T0,  LOC_SZZ};
            6'd15: u = '{OP_MULQ,   LOC_X,   LOC_Z,   LOC_T0};
            6'd16: u = '{OP_MULQ,   LOC_A,   LOC_T0,  LOC_T0};
            6'd17: u = '{OP_ADD,    LOC_SXZ, LOC_T0,  LOC_SXZ};
            6'd18: u = '{OP_ADD,    LOC_SA,  LOC_A,   LOC_SA};
            6'd19: u = '{OP_BRANCH, LOC_SA,  LOC_SA,  LOC_T0};
            6'd20: u = '{OP_CENT,   LOC_SX,  LOC_SA,  LOC_CX};
            6'd21: u = '{OP_CENT,   LOC_SY,  LOC_SA,  LOC_CY};
            6'd22: u = '{OP_CENT,   LOC_SZ,  LOC_SA,  LOC_CZ};
            6'd23: u = '{OP_MULQ,   LOC_CX,  LOC_CX,  LOC_XX2};
            6'd24: u = '{OP_MULQ,   LOC_CY,  LOC_CY,  LOC_YY2};
            6'd25: u = '{OP_MULQ,   LOC_CZ,  LOC_CZ,  LOC_ZZ2};
            6'd26: u = '{OP_ADD,    LOC_YY2, LOC_ZZ2, LOC_T0};
            6'd27: u = '{OP_MULQ,   LOC_SA,  LOC_T0,  LOC_T0};
            6'd28: u = '{OP_ADD,    LOC_SYY, LOC_SZZ, LOC_T1};
            6'd29: u = '{OP_SUB,    LOC_T1,  LOC_T0,  LOC_IXX};
            6'd30: u = '{OP_ADD,    LOC_XX2, LOC_ZZ2, LOC_T0};
            6'd31: u = '{OP_MULQ,   LOC_SA,  LOC_T0,  LOC_T0};
            6'd32: u = '{OP_ADD,    LOC_SXX, LOC_SZZ, LOC_T1};
            6'd33: u = '{OP_SUB,    LOC_T1,  LOC_T0,  LOC_IYY};
            6'd34: u = '{OP_ADD,    LOC_XX2, LOC_YY2, LOC_T0};
            6'd35: u = '{OP_MULQ,   LOC_SA,  LOC_T0,  LOC_T0};
            6'd36: u = '{OP_ADD,    LOC_SXX, LOC_SYY, LOC_T1};
            6'd37: u = '{OP_SUB,    LOC_T1,  LOC_T0,  LOC_IZZ};
            6'd38: u = '{OP_MULQ,   LOC_CX,  LOC_CZ,  LOC_T0};
            6'd39: u = '{OP_MULQ,   LOC_SA,  LOC_T0,  LOC_T0};
            6'd40: u = '{OP_SUB,    LOC_SXZ, LOC_T0,  LOC_IXZ};
            6'd41: u = '{OP_COG,    LOC_CX,  LOC_PX,  LOC_OCX};
            6'd42: u = '{OP_COG,    LOC_CY,  LOC_PY,  LOC_OCY};
            6'd43: u = '{OP_COG,    LOC_CZ,  LOC_PZ,  LOC_OCZ};
            6'd44: u = '{OP_SCALE,  LOC_IXX, LOC_SA,  LOC_OXX};
            6'd45: u = '{OP_SCALE,  LOC_IYY, LOC_SA,  LOC_OYY};
            6'd46: u = '{OP_SCALE,  LOC_IZZ, LOC_SA,  LOC_OZZ};
            6'd47: u = '{OP_SCALE,  LOC_IXZ, LOC_SA,  LOC_OXZ};
            default: u = '{OP_END,  LOC_T0,  LOC_T0,  LOC_T0};
        endcase
        return u;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // signed 48-bit saturation of a sign and magnitude, sign-extended to 64
    function automatic logic [63:0] clamp48(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        logic [63:0] m;
        lim = 64'd1 << 47;
        if (!neg) begin
            m = (mag >= lim) ? (lim - 64'd1) : mag;
        end else begin
            m = (mag >= lim) ? lim : mag;
            m = ~m + 64'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mai_ram.sv -----
`default_nettype none

module mai_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ----- sv/mai_mul.sv -----
`default_nettype none

module mai_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mai_pkg::mul_req_t req,
    input  wire logic [63:0]       a,
    input  wire logic [63:0]       b,
    output logic                   done,
    output logic [127:0]           prod
);

    import mai_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // one 32x32 partial product a cycle
    assign pa = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign pb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp = {32'd0, pa} * {32'd0, pb};

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:       pp_sh = {64'd0, pp};
            2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
            2'd3:       pp_sh = {pp, 64'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= req.rnd ? RND_HALF : 128'd0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

endmodule

`default_nettype wire

// ----- sv/mai_div.sv -----
`default_nettype none

module mai_div (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] num,
    input  wire logic [63:0]  den,
    output logic              done,
    output logic [63:0]       quo
);

    import mai_pkg::*;

    logic [127:0] n_reg;
    logic [63:0]  d_reg;
    logic [63:0]  r_reg;
    logic [63:0]  q_reg;
    logic         ovf_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         fin_reg;
    logic         done_reg;
    logic [64:0]  r_sh;
    logic         ge;
    logic [64:0]  r_new;
    logic         half_ge;

    // restoring division, one quotient bit a cycle
    assign r_sh    = {r_reg, n_reg[127]};
    assign ge      = r_sh >= {1'b0, d_reg};
    assign r_new   = ge ? (r_sh - {1'b0, d_reg}) : r_sh;
    assign half_ge = {r_reg, 1'b0} >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg && !fin_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (&cnt_reg)
                begin
                    fin_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num;
            d_reg   <= den;
            r_reg   <= 64'd0;
            q_reg   <= 64'd0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg && !fin_reg)
        begin
            n_reg <= {n_reg[126:0], 1'b0};
            r_reg <= r_new[63:0];
            q_reg <= {q_reg[62:0], ge};
            if (q_reg[63])
            begin
                ovf_reg <= 1'b1;
            end
        end
        else if (busy_reg && half_ge)
        begin
            // round to nearest, ties away from zero
            if (&q_reg)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                q_reg <= q_reg + 64'd1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = ovf_reg ? {64{1'b1}} : q_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ----- sv/mesh_area_inertia_accumulator.sv -----
`default_nettype none

// channel   direction  handshake          payload
// in        sink       in_valid/in_stall  in_data (centroid, area, final_tri)
// out       source     out_valid/out_stall out_data (cog, inertia, area_error)
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// a triangle runs eleven rounded products on the shared 32x32 multiplier, each a step of
// fetch, operands, issue, four partial products and writeback, nine add and branch
// steps of fetch, operands and execute, and the accept
// the final triangle adds seven 128-step bit-serial divisions
// (three centroids, four mass scalings) and the parallel-axis products
// reset clears the accumulators through their valid bits
// in_stall is high while an item is worked on; a waiting result on out does not
// block the next triangle, only the emit of the next result, during which in_stall stays high

module mesh_area_inertia_accumulator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire mai_pkg::in_t                     in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output mai_pkg::out_t                         out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mai_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    import mai_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [PC_W-1:0]     pc_reg;
    in_t                 in_reg;
    logic [31:0]         mass_reg;
    logic [31:0]         pos_x_reg;
    logic [31:0]         pos_y_reg;
    logic [31:0]         pos_z_reg;
    logic [RF_DEPTH-1:0] val_reg;
    logic                rva_reg;
    logic                rvb_reg;
    logic [63:0]         op_a_reg;
    logic [63:0]         op_b_reg;
    out_t                res_reg;
    out_t                out_reg;
    logic                out_valid_reg;

    uop_t         uop;
    logic         accept;
    logic [63:0]  rd_a;
    logic [63:0]  rd_b;
    logic [63:0]  opnd_a;
    logic [63:0]  opnd_b;
    logic [64:0]  add65;
    logic [64:0]  sub65;
    logic [63:0]  alu_val;
    logic [63:0]  mul_mag;
    logic [63:0]  mul_val;
    logic [63:0]  div_val;
    logic [127:0] prod;
    logic [63:0]  quo;
    logic         mul_done;
    logic         div_done;
    mul_req_t     mul_req;
    logic         div_start;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic [127:0] div_num;
    logic         zero_area;
    logic         wb_en;
    logic [63:0]  wb_val;
    logic         pc_inc;
    logic         clear_acc;
    logic         err_load;
    logic         ok_load;
    logic         emit_load;

    assign uop       = prog_rom(pc_reg);
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign zero_area = (op_a_reg == 64'd0);

    // accumulators and temporaries
    mai_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (wb_en && !uop.dst[RF_AW]),
        .waddr   (uop.dst[RF_AW-1:0]),
        .wdata   (wb_val),
        .raddr_a (uop.s1[RF_AW-1:0]),
        .raddr_b (uop.s2[RF_AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // an entry never written since the last clear reads as zero
    function automatic logic [63:0] pick(input loc_t c, input logic [63:0] rd, input logic rv);
        logic [63:0] v;
        if (!c[RF_AW])
        begin
            v = rv ? rd : 64'd0;
        end
        else
        begin
            unique case (c)
                LOC_X:   v = {{32{in_reg.tri_cx[31]}}, in_reg.tri_cx};
                LOC_Y:   v = {{32{in_reg.tri_cy[31]}}, in_reg.tri_cy};
                LOC_Z:   v = {{32{in_reg.tri_cz[31]}}, in_reg.tri_cz};
                LOC_A:   v = {32'd0, in_reg.tri_area};
                LOC_PX:  v = {{32{pos_x_reg[31]}}, pos_x_reg};
                LOC_PY:  v = {{32{pos_y_reg[31]}}, pos_y_reg};
                LOC_PZ:  v = {{32{pos_z_reg[31]}}, pos_z_reg};
                default: v = 64'd0;
            endcase
        end
        return v;
    endfunction

    assign opnd_a = pick(uop.s1, rd_a, rva_reg);
    assign opnd_b = pick(uop.s2, rd_b, rvb_reg);

    // saturating add, subtract and the 32-bit offset clamp
    assign add65 = {op_a_reg[63], op_a_reg} + {op_b_reg[63], op_b_reg};
    assign sub65 = {op_a_reg[63], op_a_reg} - {op_b_reg[63], op_b_reg};

    always_comb
    begin
        logic [64:0] s;
        s = (uop.op == OP_ADD) ? add65 : sub65;
        alu_val = s[63:0];
        if (uop.op == OP_COG)
        begin
            // both sides are well inside 64 bits, so only the 32-bit clamp matters
            if (!((&s[63:31]) || !(|s[63:31])))
            begin
                alu_val = s[63] ? {{33{1'b1}}, 31'd0} : {33'd0, {31{1'b1}}};
            end
        end
        else if (s[64] != s[63])
        begin
            alu_val = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

    // rounded product back to the fixed-point scale, then 48-bit saturation
    assign mul_mag = (|prod[127:64+FRAC_BITS]) ? {64{1'b1}} : prod[63+FRAC_BITS:FRAC_BITS];
    assign mul_val = clamp48(op_a_reg[63] ^ op_b_reg[63], mul_mag);
    assign div_val = clamp48(op_a_reg[63], quo);

    assign mul_a   = mag64(op_a_reg);
    assign mul_b   = (uop.op == OP_SCALE) ? {32'd0, mass_reg} : mag64(op_b_reg);
    assign div_num = (uop.op == OP_CENT) ? ({64'd0, mag64(op_a_reg)} << FRAC_BITS) : prod;

    mai_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    mai_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (op_b_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_OPER;
            ST_OPER:  state_next = ST_EXEC;
            ST_EXEC:
            begin
                unique case (uop.op)
                    OP_MULQ, OP_SCALE: state_next = ST_MUL;
                    OP_CENT:           state_next = ST_DIV;
                    OP_BRANCH:
                    begin
                        priority if (!in_reg.final_tri)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (zero_area)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                    OP_END:                   state_next = ST_EMIT;
                    OP_ADD, OP_SUB, OP_COG:   state_next = ST_FETCH;
                endcase
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = (uop.op == OP_SCALE) ? ST_DIV : ST_FETCH;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mul_req   = '{start: 1'b0, rnd: (uop.op == OP_MULQ)};
        div_start = 1'b0;
        wb_en     = 1'b0;
        wb_val    = alu_val;
        clear_acc = 1'b0;
        err_load  = 1'b0;
        ok_load   = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                unique case (uop.op)
                    OP_MULQ, OP_SCALE: mul_req.start = 1'b1;
                    OP_CENT:           div_start     = 1'b1;
                    OP_ADD, OP_SUB, OP_COG: wb_en    = 1'b1;
                    OP_BRANCH:
                    begin
                        err_load  = in_reg.final_tri && zero_area;
                        clear_acc = in_reg.final_tri && zero_area;
                    end
                    OP_END:
                    begin
                        ok_load   = 1'b1;
                        clear_acc = 1'b1;
                    end
                endcase
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start = (uop.op == OP_SCALE);
                    wb_en     = (uop.op == OP_MULQ);
                    wb_val    = mul_val;
                end
            end
            ST_DIV:
            begin
                wb_en  = div_done;
                wb_val = div_val;
            end
            ST_EMIT:
            begin
                emit_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                wb_en = 1'b0;
            end
        endcase
        pc_inc = (state_next == ST_FETCH) && (state_reg != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            val_reg       <= '0;
            out_valid_reg <= 1'b0;
            mass_reg      <= MASS_RESET;
            pos_x_reg     <= 32'd0;
            pos_y_reg     <= 32'd0;
            pos_z_reg     <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pc_reg <= '0;
            end
            else if (pc_inc)
            begin
                pc_reg <= pc_reg + PC_W'(1);
            end
            if (clear_acc)
            begin
                val_reg <= '0;
            end
            else if (wb_en && !uop.dst[RF_AW])
            begin
                val_reg[uop.dst[RF_AW-1:0]] <= 1'b1;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MASS:  mass_reg  <= cfg_data;
                    CFG_POS_X: pos_x_reg <= cfg_data;
                    CFG_POS_Y: pos_y_reg <= cfg_data;
                    CFG_POS_Z: pos_z_reg <= cfg_data;
                    default:   mass_reg  <= mass_reg;
                endcase
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        rva_reg <= val_reg[uop.s1[RF_AW-1:0]];
        rvb_reg <= val_reg[uop.s2[RF_AW-1:0]];
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (state_reg == ST_OPER)
        begin
            op_a_reg <= opnd_a;
            op_b_reg <= opnd_b;
        end
        if (err_load)
        begin
            // error result: every field zero but the flag
            res_reg <= '{area_error: 1'b1, default: '0};
        end
        else if (ok_load)
        begin
            res_reg.area_error <= 1'b0;
        end
        else if (wb_en && uop.dst[RF_AW])
        begin
            unique case (uop.dst)
                LOC_OCX: res_reg.cog_x      <= wb_val[31:0];
                LOC_OCY: res_reg.cog_y      <= wb_val[31:0];
                LOC_OCZ: res_reg.cog_z      <= wb_val[31:0];
                LOC_OXX: res_reg.inertia_xx <= wb_val[47:0];
                LOC_OYY: res_reg.inertia_yy <= wb_val[47:0];
                LOC_OZZ: res_reg.inertia_zz <= wb_val[47:0];
                LOC_OXZ: res_reg.inertia_xz <= wb_val[47:0];
                default: res_reg.area_error <= res_reg.area_error;
            endcase
        end
        if (emit_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        clear_acc |=> (val_reg == '0))
        else $error("accumulators not cleared after final triangle");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && res_reg.area_error) |-> ((res_reg.inertia_xx == '0) &&
        (res_reg.cog_x == '0)))
        else $error("area error result carries nonzero fields");

    a_mul_op: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL) && mul_done) |-> ((uop.op == OP_MULQ) ||
        (uop.op == OP_SCALE)))
        else $error("product finished under a non-multiply step");

endmodule

`default_nettype wire
